// File: src/pcta_pkg.sv
`timescale 1ns / 1ps

package pcta_pkg;

  localparam int MAX_CELLS = 65536;
  localparam int ADDR_W = $clog2(MAX_CELLS);

  localparam int STEP_W = 24;
  localparam logic [STEP_W-1:0] STEP_LIMIT = 24'hFFFFFF;

  localparam logic [2:0] MODE_SUM  = 3'd0;
  localparam logic [2:0] MODE_MEAN = 3'd1;
  localparam logic [2:0] MODE_MIN  = 3'd2;
  localparam logic [2:0] MODE_MAX  = 3'd3;

  localparam logic [1:0] REG_AGG_MODE     = 2'd0;
  localparam logic [1:0] REG_BLANK_VALUE  = 2'd1;
  localparam logic [1:0] REG_CELLS_IN_USE = 2'd2;

  localparam logic [31:0] NODATA_RESET = 32'hD8F10000;
  localparam logic [16:0] CELLS_RESET  = 17'd65536;

  localparam logic [31:0] Q_MAX = 32'h7FFFFFFF;
  localparam logic [31:0] Q_MIN = 32'h80000000;

endpackage

// File: src/per_cell_temporal_aggregator.sv
`timescale 1ns / 1ps

// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+---------------------------
// input     | cell_index, sample_value, step_end           | start high, busy low
// result    | cell_number, aggregate_value, has_data,      | done high for one cycle
//           | saturated                                    |
// config    | cfg_index, cfg_data                          | cfg_write high
//
// Sum, minimum, maximum and no-update items pass S_READ and S_EVAL; done is registered
// at the end of S_EVAL. Mean items go on through S_MUL, then a radix-2 divider at one
// quotient bit per cycle over 32 bits (S_DIV), then the cell store write-back (S_WB).
// After rst the cell store is swept once, one entry per cycle, with busy high;
// configuration writes are taken during the sweep.
// A new item can be accepted in the cycle done is high; done cannot be stalled.

module per_cell_temporal_aggregator
  import pcta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic        [15:0] cell_index,
  input  logic signed [31:0] sample_value,
  input  logic               step_end,
  output logic               done,
  output logic        [15:0] cell_number,
  output logic signed [31:0] aggregate_value,
  output logic               has_data,
  output logic               saturated,
  input  logic               cfg_write,
  input  logic         [1:0] cfg_index,
  input  logic        [31:0] cfg_data
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_WB    = 7'b1000000
  } state_t;

  state_t state;

  logic [2:0]  agg_mode;
  logic [31:0] blank_value;
  logic [16:0] cells_in_use;
  logic [STEP_W-1:0] step_count;

  logic [32:0] mem [MAX_CELLS];
  logic [32:0] rdata;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [32:0] mem_wdata;
  logic [ADDR_W-1:0] clr_cnt;

  logic [ADDR_W-1:0] addr_q;
  logic [15:0]       index_q;
  logic [31:0]       sample_q;
  logic              in_range_q;
  logic [STEP_W-1:0] n_q;
  logic [STEP_W:0]   d_q;

  logic signed [STEP_W+32:0] prod;
  logic        neg_q;
  logic [31:0] div_hi;
  logic [31:0] div_lo;
  logic [4:0]  div_cnt;

  logic        accept;
  logic        in_range;
  logic        cur_valid;
  logic [31:0] cur;
  logic [31:0] base;
  logic        upd;
  logic [32:0] sum_wide;
  logic        sum_ovf;
  logic [31:0] sum_val;
  logic [31:0] new_val;
  logic signed [STEP_W+32:0] num;
  logic        num_neg;
  logic [STEP_W+32:0] mag;
  logic [63:0] dvd;
  logic [32:0] div_top;
  logic        div_ge;
  logic [31:0] mean_val;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign in_range = ({1'b0, cell_index} < cells_in_use) &&
                    (32'(cell_index) < 32'(MAX_CELLS));

  assign cur_valid = rdata[32];
  assign cur       = rdata[31:0];

  always_comb begin
    if (cur_valid) begin
      base = cur;
    end else if (agg_mode == MODE_MIN) begin
      base = Q_MAX;
    end else if (agg_mode == MODE_MAX) begin
      base = Q_MIN;
    end else begin
      base = '0;
    end
  end

  assign upd = in_range_q && (sample_q != blank_value) && (agg_mode <= MODE_MAX);

  assign sum_wide = {base[31], base} + {sample_q[31], sample_q};
  assign sum_ovf  = sum_wide[32] != sum_wide[31];
  assign sum_val  = sum_ovf ? (sum_wide[32] ? Q_MIN : Q_MAX) : sum_wide[31:0];

  always_comb begin
    unique case (agg_mode)
      MODE_MIN: new_val = ($signed(sample_q) <= $signed(base)) ? sample_q : base;
      MODE_MAX: new_val = ($signed(sample_q) >= $signed(base)) ? sample_q : base;
      default:  new_val = sum_val;
    endcase
  end

  assign num     = prod + (STEP_W+33)'($signed(sample_q));
  assign num_neg = num[STEP_W+32];
  assign mag     = num_neg ? (STEP_W+33)'(-num) : (STEP_W+33)'(num);
  assign dvd     = 64'(mag) + 64'(d_q >> 1);

  assign div_top = {div_hi, div_lo[31]};
  assign div_ge  = div_top >= 33'(d_q);

  assign mean_val = neg_q ? 32'(-div_lo) : (div_lo[31] ? Q_MAX : div_lo);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = {1'b1, new_val};
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_EVAL: begin
        mem_we = upd && (agg_mode != MODE_MEAN);
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, mean_val};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[addr_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      agg_mode     <= MODE_SUM;
      blank_value  <= NODATA_RESET;
      cells_in_use <= CELLS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AGG_MODE:     agg_mode     <= cfg_data[2:0];
        REG_BLANK_VALUE:  blank_value  <= cfg_data;
        REG_CELLS_IN_USE: cells_in_use <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q     <= ADDR_W'(cell_index);
      index_q    <= cell_index;
      sample_q   <= sample_value;
      in_range_q <= in_range;
      n_q        <= step_count;
      d_q        <= {1'b0, step_count} + 1'b1;
    end
    if (state == S_EVAL) begin
      prod <= (STEP_W+33)'($signed(base)) * (STEP_W+33)'($signed({1'b0, n_q}));
    end
    if (state == S_MUL) begin
      neg_q  <= num_neg;
      div_hi <= dvd[63:32];
      div_lo <= dvd[31:0];
    end
    if (state == S_DIV) begin
      div_hi <= div_ge ? 32'(div_top - 33'(d_q)) : div_top[31:0];
      div_lo <= {div_lo[30:0], div_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      div_cnt    <= '0;
      step_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept && step_end && (step_count != STEP_LIMIT)) begin
        step_count <= step_count + 1'b1;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(MAX_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (upd && (agg_mode == MODE_MEAN)) begin
            state <= S_MUL;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_MUL: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 5'd31) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      cell_number <= index_q;
      saturated   <= upd && (agg_mode == MODE_SUM) && sum_ovf;
      if (upd) begin
        aggregate_value <= new_val;
        has_data        <= 1'b1;
      end else if (in_range_q && cur_valid) begin
        aggregate_value <= cur;
        has_data        <= 1'b1;
      end else begin
        aggregate_value <= blank_value;
        has_data        <= 1'b0;
      end
    end else if (state == S_WB) begin
      aggregate_value <= mean_val;
      has_data        <= 1'b1;
      saturated       <= 1'b0;
    end
  end

endmodule

// File: src/pcta_chk.sv
`timescale 1ns / 1ps

module pcta_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic has_data,
  input logic saturated
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low after an accepted item");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work in progress");

  a_sat_data: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> has_data)
    else $error("saturated result without data");

endmodule

bind per_cell_temporal_aggregator pcta_chk u_pcta_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .has_data  (has_data),
  .saturated (saturated)
);

// File: verif/per_cell_temporal_aggregator_tb.sv
`timescale 1ns / 1ps

module per_cell_temporal_aggregator_tb;
  import pcta_pkg::*;

  localparam logic [2:0] MODE_NONE = 3'd4;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 12;

  typedef enum logic [1:0] {CMD_ITEM, CMD_DRAIN, CMD_WRITE} cmd_kind_t;

  typedef struct {
    cmd_kind_t          kind;
    logic        [15:0] idx;
    logic signed [31:0] value;
    logic               last;
    logic         [1:0] reg_sel;
    logic        [31:0] reg_data;
    bit                 steady;
  } sample_cmd_t;

  typedef struct {
    logic        [15:0] cell_id;
    logic signed [31:0] agg;
    logic               has;
    logic               sat;
  } cell_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic        [15:0] cell_index = '0;
  logic signed [31:0] sample_value = '0;
  logic               step_end = 1'b0;
  logic               done;
  logic        [15:0] cell_number;
  logic signed [31:0] aggregate_value;
  logic               has_data;
  logic               saturated;
  logic               cfg_write = 1'b0;
  logic         [1:0] cfg_index = '0;
  logic        [31:0] cfg_data = '0;

  sample_cmd_t  pending_q[$];
  cell_result_t expected_aggs[$];
  int           errors = 0;
  int           cycles = 0;

  logic        [2:0] mode_q = MODE_SUM;
  logic signed [31:0] nodata_q = NODATA_RESET;
  logic       [16:0] cells_q = CELLS_RESET;
  logic       [23:0] steps_q = '0;
  logic signed [31:0] cell_store [0:MAX_CELLS-1];
  bit                cell_filled [0:MAX_CELLS-1];

  per_cell_temporal_aggregator dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cell_index     (cell_index),
    .sample_value   (sample_value),
    .step_end       (step_end),
    .done           (done),
    .cell_number    (cell_number),
    .aggregate_value(aggregate_value),
    .has_data       (has_data),
    .saturated      (saturated),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic signed [31:0] running_mean(logic signed [31:0] prev,
                                                      logic signed [31:0] x,
                                                      logic [23:0] n);
    logic signed [63:0] num;
    logic        [63:0] mag;
    logic        [63:0] d;
    logic        [63:0] q;
    num = prev * $signed({40'd0, n}) + x;
    d = {40'd0, n} + 64'd1;
    mag = (num < 0) ? -num : num;
    q = (mag + (d >> 1)) / d;
    if (num < 0)
      return (q >= 64'h80000000) ? Q_MIN : -q[31:0];
    return (q > 64'h7FFFFFFF) ? Q_MAX : q[31:0];
  endfunction

  function automatic cell_result_t aggregate_sample(logic [15:0] idx,
                                                    logic signed [31:0] x,
                                                    logic last);
    cell_result_t       r;
    logic signed [31:0] cur;
    logic signed [63:0] wide;
    r.cell_id = idx;
    r.agg = nodata_q;
    r.has = 1'b0;
    r.sat = 1'b0;
    if ({1'b0, idx} < cells_q && 32'(idx) < MAX_CELLS) begin
      if (x != nodata_q && mode_q <= MODE_MAX) begin
        if (cell_filled[idx])
          cur = cell_store[idx];
        else if (mode_q == MODE_MIN)
          cur = Q_MAX;
        else if (mode_q == MODE_MAX)
          cur = Q_MIN;
        else
          cur = '0;
        case (mode_q)
          MODE_SUM: begin
            wide = cur + x;
            if (wide > 64'sh7FFFFFFF) begin
              cur = Q_MAX;
              r.sat = 1'b1;
            end else if (wide < -64'sh80000000) begin
              cur = Q_MIN;
              r.sat = 1'b1;
            end else begin
              cur = wide[31:0];
            end
          end
          MODE_MEAN: cur = running_mean(cur, x, steps_q);
          MODE_MIN: if (x <= cur) cur = x;
          default: if (x >= cur) cur = x;
        endcase
        cell_store[idx] = cur;
        cell_filled[idx] = 1'b1;
      end
      if (cell_filled[idx]) begin
        r.agg = cell_store[idx];
        r.has = 1'b1;
      end
    end
    if (last && steps_q != STEP_LIMIT)
      steps_q = steps_q + 1'b1;
    return r;
  endfunction

  function automatic void apply_register(logic [1:0] sel, logic [31:0] data);
    case (sel)
      REG_AGG_MODE: mode_q = data[2:0];
      REG_BLANK_VALUE: nodata_q = data;
      REG_CELLS_IN_USE: cells_q = data[16:0];
      default: ;
    endcase
  endfunction

  task automatic add_item(logic [15:0] idx, logic signed [31:0] value, logic last,
                          bit steady = 1'b0);
    sample_cmd_t c;
    c = '{CMD_ITEM, idx, value, last, '0, '0, steady};
    pending_q.push_back(c);
  endtask

  task automatic add_write(logic [1:0] sel, logic [31:0] data);
    sample_cmd_t c;
    c = '{CMD_DRAIN, '0, '0, 1'b0, '0, '0, 1'b0};
    pending_q.push_back(c);
    c = '{CMD_WRITE, '0, '0, 1'b0, sel, data, 1'b0};
    pending_q.push_back(c);
  endtask

  function automatic logic signed [31:0] rand_sample(logic signed [31:0] nodata);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)
      return nodata;
    if (pick < 12)
      return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    if (pick < 55)
      return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
    return $urandom;
  endfunction

  task automatic build_directed();
    add_item(16'd0, Q_MAX, 1'b0);
    add_item(16'd0, 32'sd1, 1'b0);
    add_item(16'hFFFF, Q_MIN, 1'b0);
    add_item(16'hFFFF, -32'sd1, 1'b0);
    add_item(16'd7, NODATA_RESET, 1'b0);
    add_item(16'd0, NODATA_RESET, 1'b1);
    add_write(REG_AGG_MODE, 32'(MODE_MEAN));
    add_write(REG_CELLS_IN_USE, 32'd16);
    add_item(16'd3, 32'sh00030000, 1'b0);
    add_item(16'd3, -32'sh00010000, 1'b1);
    add_item(16'd20, 32'sd5, 1'b0);
    add_item(16'd3, Q_MIN, 1'b1);
    add_write(REG_AGG_MODE, 32'(MODE_MIN));
    add_item(16'd4, 32'sd100, 1'b0);
    add_item(16'd4, Q_MAX, 1'b0);
    add_item(16'd4, -32'sd100, 1'b0);
    add_write(REG_AGG_MODE, 32'(MODE_MAX));
    add_item(16'd4, Q_MIN, 1'b0);
    add_item(16'd9, Q_MIN, 1'b0);
    add_write(REG_AGG_MODE, 32'(MODE_NONE));
    add_item(16'd4, 32'sd7, 1'b0);
    add_write(REG_AGG_MODE, 32'(MODE_UNUSED));
    add_item(16'd4, 32'sd7, 1'b1);
    add_write(REG_CELLS_IN_USE, 32'd0);
    add_item(16'd0, 32'sd1, 1'b0);
    add_write(REG_CELLS_IN_USE, 32'h10000);
    add_write(REG_AGG_MODE, 32'(MODE_SUM));
    add_write(REG_BLANK_VALUE, 32'h00010000);
    add_item(16'd30, 32'sh8000, 1'b0);
    add_item(16'd30, 32'sh8000, 1'b0);
    add_item(16'd30, 32'sh10000, 1'b0);
    add_item(16'd7, 32'sh10000, 1'b0);
  endtask

  task automatic build_random();
    int          n_items;
    int          at;
    logic [16:0] cells;
    logic [31:0] nodata;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      n_items = (p == RANDOM_PHASES - 1) ? 40 : 150;
      if (p == RANDOM_PHASES - 1)
        add_write(REG_AGG_MODE, $urandom_range(MODE_NONE, MODE_UNUSED));
      else
        add_write(REG_AGG_MODE, (p < 4) ? p : $urandom_range(MODE_SUM, MODE_MAX));
      case ($urandom_range(0, 3))
        0: nodata = $urandom;
        1: nodata = ($urandom_range(0, 4) - 2) << 16;
        default: nodata = NODATA_RESET;
      endcase
      add_write(REG_BLANK_VALUE, nodata);
      if (p == 0)
        cells = CELLS_RESET;
      else if (p == 1)
        cells = 17'd1;
      else if ($urandom_range(0, 9) == 0)
        cells = 17'($urandom_range(1, MAX_CELLS));
      else
        cells = 17'($urandom_range(2, 48));
      add_write(REG_CELLS_IN_USE, 32'(cells));
      at = 0;
      for (int k = 0; k < n_items; k++) begin
        if (cells > 64)
          add_item(16'($urandom_range(0, 65535)), rand_sample(nodata),
                   $urandom_range(0, 19) == 0, p == 5);
        else if ($urandom_range(0, 9) == 0)
          add_item(16'($urandom_range(0, 65535)), rand_sample(nodata),
                   1'($urandom_range(0, 1)), p == 5);
        else begin
          add_item(16'(at), rand_sample(nodata), at == cells - 1, p == 5);
          at = (at + 1) % cells;
        end
      end
    end
  endtask

  sample_cmd_t head;
  bit          raise;
  bit          write_now;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      raise = start;
      write_now = 1'b0;
      if (start && !busy) begin
        expected_aggs.push_back(aggregate_sample(cell_index, sample_value, step_end));
        raise = 1'b0;
      end
      if (!raise && pending_q.size() > 0 &&
          (pending_q[0].steady || $urandom_range(0, 99) >= 25) &&
          !(pending_q[0].kind == CMD_DRAIN && expected_aggs.size() != 0)) begin
        head = pending_q.pop_front();
        case (head.kind)
          CMD_ITEM: begin
            cell_index <= head.idx;
            sample_value <= head.value;
            step_end <= head.last;
            raise = 1'b1;
          end
          CMD_WRITE: begin
            cfg_index <= head.reg_sel;
            cfg_data <= head.reg_data;
            apply_register(head.reg_sel, head.reg_data);
            write_now = 1'b1;
          end
          default: ;
        endcase
      end
      start <= raise;
      cfg_write <= write_now;
    end
  end

  cell_result_t want;

  always @(negedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_aggs.size() == 0) begin
        $error("result with nothing expected: cell_number %0d", cell_number);
        errors++;
      end else begin
        want = expected_aggs.pop_front();
        if (cell_number !== want.cell_id) begin
          $error("cell_number: expected %0d, got %0d", want.cell_id, cell_number);
          errors++;
        end
        if (aggregate_value !== want.agg) begin
          $error("aggregate_value: expected %h, got %h", want.agg, aggregate_value);
          errors++;
        end
        if (has_data !== want.has) begin
          $error("has_data: expected %b, got %b", want.has, has_data);
          errors++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() != 0 || start || expected_aggs.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
